@@ hw/rtl/lpse_pkg.sv @@
// ----------------------------------------------------------------------------
// lpse_pkg
// Types, constants and pulse helpers shared by the LED pulse SPI encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

    localparam int unsigned RunLimit   = 64;
    localparam int unsigned CountW     = 7;
    localparam int unsigned ColourW    = 24;
    localparam int unsigned CfgIndexW  = 3;
    localparam int unsigned CfgDataW   = 7;
    localparam int unsigned QueueDepth = 2;

    // bytes per LED word
    localparam logic [CountW-1:0] LedBytesSingle = 7'd24;
    localparam logic [CountW-1:0] LedBytesDouble = 7'd12;

    typedef enum logic [1:0] {
        OP_LED   = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_ZERO_LEN   = 3'd0,
        REG_ONE_LEN    = 3'd1,
        REG_LEAD_LOW   = 3'd2,
        REG_MSB_FIRST  = 3'd3,
        REG_DOUBLE     = 3'd4,
        REG_PREFIX     = 3'd5,
        REG_SUFFIX     = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [2:0]        zero_pulse_len;
        logic [2:0]        one_pulse_len;
        logic              lead_low_bit;
        logic              msb_first;
        logic              double_packing;
        logic [CountW-1:0] prefix_count;
        logic [CountW-1:0] suffix_count;
    } cfg_t;

    // one queued job: a colour word or a run of zero bytes
    typedef struct packed {
        logic               is_led;
        logic [CountW-1:0]  count;
        logic [ColourW-1:0] colours;   // green in the top byte, blue at the bottom
    } cmd_t;

    // run of ones, optionally moved up one place, cut to a byte
    function automatic logic [7:0] pulse_raw(input logic [2:0] len, input logic lead);
        logic [7:0] p;
        p = (8'd1 << len) - 8'd1;
        return p << lead;
    endfunction

    function automatic logic [7:0] pulse8(input logic [2:0] len, input logic lead,
                                          input logic msb);
        logic [7:0] p;
        logic [7:0] r;
        p = pulse_raw(len, lead);
        for (int i = 0; i < 8; i++) begin
            r[i] = p[7-i];
        end
        return msb ? r : p;
    endfunction

    function automatic logic [3:0] pulse4(input logic [2:0] len, input logic lead,
                                          input logic msb);
        logic [7:0] p;
        logic [3:0] n;
        p = pulse_raw(len, lead);
        n = p[3:0];
        return msb ? {n[0], n[1], n[2], n[3]} : n;
    endfunction

endpackage

@@ hw/rtl/lpse_front.sv @@
// ----------------------------------------------------------------------------
// lpse_front
// Classifies input words into encoder jobs and drops those with no output.
// ----------------------------------------------------------------------------
module lpse_front
(
    input  logic                 in_valid,
    input  logic [1:0]           in_op,
    input  logic [23:0]          in_colours,
    input  lpse_pkg::cfg_t       cfg,
    output logic                 push,
    output lpse_pkg::cmd_t       cmd
);

    logic [lpse_pkg::CountW-1:0] run_len;
    logic [lpse_pkg::CountW-1:0] run_sat;
    logic                        has_output;

    always_comb
    begin
        run_len    = '0;
        has_output = 1'b0;
        case (lpse_pkg::op_t'(in_op))
            lpse_pkg::OP_LED:
            begin
                has_output = 1'b1;
            end
            lpse_pkg::OP_START:
            begin
                run_len    = cfg.prefix_count;
                has_output = (cfg.prefix_count != '0);
            end
            lpse_pkg::OP_END:
            begin
                run_len    = cfg.suffix_count;
                has_output = (cfg.suffix_count != '0);
            end
            default:
            begin
                has_output = 1'b0;
            end
        endcase

        // runs longer than the limit saturate
        if (run_len > lpse_pkg::CountW'(lpse_pkg::RunLimit)) begin
            run_sat = lpse_pkg::CountW'(lpse_pkg::RunLimit);
        end else begin
            run_sat = run_len;
        end

        cmd.is_led  = (lpse_pkg::op_t'(in_op) == lpse_pkg::OP_LED);
        cmd.colours = in_colours;
        if (cmd.is_led) begin
            cmd.count = cfg.double_packing ? lpse_pkg::LedBytesDouble
                                           : lpse_pkg::LedBytesSingle;
        end else begin
            cmd.count = run_sat;
        end
        push = in_valid && has_output;
    end

endmodule

@@ hw/rtl/lpse_queue.sv @@
// ----------------------------------------------------------------------------
// lpse_queue
// Short job queue between the classifier and the byte generator.
// ----------------------------------------------------------------------------
module lpse_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpse_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lpse_pkg::cmd_t head
);

    localparam int unsigned PtrW = $clog2(lpse_pkg::QueueDepth);

    lpse_pkg::cmd_t  mem [lpse_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW:0]   fill_reg;
    logic [PtrW:0]   fill_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (fill_reg == (PtrW+1)'(lpse_pkg::QueueDepth));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/lpse_back.sv @@
// ----------------------------------------------------------------------------
// lpse_back
// Byte generator: walks one job a byte per cycle into the output register unless the output stalls.
// ----------------------------------------------------------------------------
module lpse_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpse_pkg::cfg_t       cfg,
    input  logic                 q_empty,
    input  lpse_pkg::cmd_t       q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    logic                        cur_valid_reg;
    logic                        cur_valid_next;
    logic                        cur_led_reg;
    logic [lpse_pkg::CountW-1:0] cur_left_reg;
    logic [lpse_pkg::CountW-1:0] cur_left_next;
    logic [lpse_pkg::ColourW-1:0] cur_bits_reg;
    logic [lpse_pkg::ColourW-1:0] cur_bits_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        out_last_reg;

    logic                        slot_free;
    logic                        emit;
    logic                        is_last;
    logic [7:0]                  pat0;
    logic [7:0]                  pat1;
    logic [3:0]                  nib0;
    logic [3:0]                  nib1;
    logic [3:0]                  first_nib;
    logic [3:0]                  second_nib;
    logic [7:0]                  byte_val;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && slot_free;
    assign is_last   = (cur_left_reg == lpse_pkg::CountW'(1));
    assign q_pop     = !q_empty && (!cur_valid_reg || (emit && is_last));

    always_comb
    begin
        pat0       = lpse_pkg::pulse8(cfg.zero_pulse_len, cfg.lead_low_bit, cfg.msb_first);
        pat1       = lpse_pkg::pulse8(cfg.one_pulse_len, cfg.lead_low_bit, cfg.msb_first);
        nib0       = lpse_pkg::pulse4(cfg.zero_pulse_len, cfg.lead_low_bit, cfg.msb_first);
        nib1       = lpse_pkg::pulse4(cfg.one_pulse_len, cfg.lead_low_bit, cfg.msb_first);
        first_nib  = cur_bits_reg[23] ? nib1 : nib0;
        second_nib = cur_bits_reg[22] ? nib1 : nib0;

        if (!cur_led_reg) begin
            byte_val = 8'h00;
        end else if (cfg.double_packing) begin
            byte_val = cfg.msb_first ? {first_nib, second_nib} : {second_nib, first_nib};
        end else begin
            byte_val = cur_bits_reg[23] ? pat1 : pat0;
        end

        cur_valid_next = cur_valid_reg;
        cur_left_next  = cur_left_reg;
        cur_bits_next  = cur_bits_reg;
        if (emit) begin
            cur_left_next = cur_left_reg - 1'b1;
            cur_bits_next = cfg.double_packing ? {cur_bits_reg[21:0], 2'b00}
                                               : {cur_bits_reg[22:0], 1'b0};
            if (is_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_left_next  = q_head.count;
            cur_bits_next  = q_head.colours;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            cur_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            cur_left_reg  <= cur_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bits_reg <= cur_bits_next;
        if (q_pop) begin
            cur_led_reg <= q_head.is_led;
        end
        if (emit) begin
            out_byte_reg <= byte_val;
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hw/rtl/led_pulse_spi_encoder.sv @@
// ----------------------------------------------------------------------------
// led_pulse_spi_encoder
// Encodes LED colour words and frame markers into SPI pulse bytes.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Word
// s_*       in   s_tvalid/s_tready    tdata colours, tuser op
// m_*       out  m_tvalid/m_tready    tdata spi_byte, tlast last of run
// cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One output byte per cycle unless the output stalls: an LED word gives 24 bytes
// (12 in double packing), a frame marker one zero byte per count; the byte counter
// in the generator sets this. Input words are taken while the two-entry job queue
// has room, so a queued job starts the cycle after the last byte of the previous.
// Reset restores register defaults and empties queue and output register.
// ----------------------------------------------------------------------------
module led_pulse_spi_encoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // green [7:0], red [15:8], blue [23:16]
    input  logic [1:0]  s_tuser,   // op [1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // spi_byte [7:0]
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    lpse_pkg::cfg_t cfg_reg;
    lpse_pkg::cfg_t cfg_next;
    lpse_pkg::cmd_t front_cmd;
    lpse_pkg::cmd_t q_head;
    logic           front_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (lpse_pkg::reg_index_t'(cfg_index))
                lpse_pkg::REG_ZERO_LEN:  cfg_next.zero_pulse_len = cfg_data[2:0];
                lpse_pkg::REG_ONE_LEN:   cfg_next.one_pulse_len  = cfg_data[2:0];
                lpse_pkg::REG_LEAD_LOW:  cfg_next.lead_low_bit   = cfg_data[0];
                lpse_pkg::REG_MSB_FIRST: cfg_next.msb_first      = cfg_data[0];
                lpse_pkg::REG_DOUBLE:    cfg_next.double_packing = cfg_data[0];
                lpse_pkg::REG_PREFIX:    cfg_next.prefix_count   = cfg_data;
                lpse_pkg::REG_SUFFIX:    cfg_next.suffix_count   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.zero_pulse_len <= 3'd1;
            cfg_reg.one_pulse_len  <= 3'd3;
            cfg_reg.lead_low_bit   <= 1'b0;
            cfg_reg.msb_first      <= 1'b1;
            cfg_reg.double_packing <= 1'b0;
            cfg_reg.prefix_count   <= '0;
            cfg_reg.suffix_count   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // words with no output are taken and dropped
    assign s_tready = !q_full;

    lpse_front u_front
    (
        .in_valid   (s_tvalid && !q_full),
        .in_op      (s_tuser),
        .in_colours ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .cfg        (cfg_reg),
        .push       (front_push),
        .cmd        (front_cmd)
    );

    lpse_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    lpse_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_pulse_spi_encoder. A table of directed words
// runs first, at the reset settings and then across extreme register settings.
// Random frames follow: start marker, LED words and mostly an end marker, with the odd
// ignored op. Each output byte is checked against the table or a local encoder model.
// Both stream sides idle at random. One phase holds the output off for a long
// stretch, and one runs with no idling at all.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned WORDS_PER_PHASE = 18;
    localparam int DIRECTED_ROWS = 24;

    typedef struct {
        logic [7:0] spi_byte;
        logic       last_of_run;
    } spi_word_t;

    typedef struct {
        int              setting;
        lpse_pkg::op_t   op;
        logic [23:0]     colours;   // green [7:0], red [15:8], blue [23:16]
        bit              typed;
        logic [7:0]      run_byte;
        int              run_len;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // green [7:0], red [15:8], blue [23:16]
    logic [1:0]  s_tuser = '0;   // op [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // spi_byte [7:0]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    lpse_pkg::cfg_t shadow;
    spi_word_t      pending_spi_q[$];
    int unsigned    mismatches = 0;
    int unsigned    bytes_checked = 0;
    int unsigned    words_sent = 0;
    int unsigned    settings_applied = 0;
    int unsigned    cycle_count = 0;
    bit             steady = 1'b0;
    bit             hold_request = 1'b0;

    // zero len, one len, lead low, msb first, double, prefix, suffix
    lpse_pkg::cfg_t presets [5] = '{
        '{3'd1, 3'd3, 1'b0, 1'b1, 1'b0, 7'd0,   7'd0},
        '{3'd0, 3'd7, 1'b1, 1'b0, 1'b1, 7'd127, 7'd64},
        '{3'd7, 3'd0, 1'b0, 1'b1, 1'b1, 7'd1,   7'd100},
        '{3'd4, 3'd2, 1'b1, 1'b1, 1'b0, 7'd0,   7'd3},
        '{3'd2, 3'd5, 1'b0, 1'b0, 1'b0, 7'd64,  7'd0}
    };

    stim_row_t directed [DIRECTED_ROWS] = '{
        // reset settings: zero pulse 0x80, one pulse 0xe0
        '{0, lpse_pkg::OP_LED,   24'h000000, 1'b1, 8'h80, 24},
        '{0, lpse_pkg::OP_LED,   24'hffffff, 1'b1, 8'he0, 24},
        '{0, lpse_pkg::OP_LED,   24'h813ca5, 1'b0, 8'h00, 0},
        '{0, lpse_pkg::OP_START, 24'h000000, 1'b1, 8'h00, 0},
        '{0, lpse_pkg::OP_END,   24'hffffff, 1'b1, 8'h00, 0},
        '{0, lpse_pkg::OP_NONE,  24'hffffff, 1'b1, 8'h00, 0},
        '{0, lpse_pkg::OP_LED,   24'h00ff00, 1'b0, 8'h00, 0},
        // empty zero pulse, nibble overflow, lsb first, counts saturate
        '{1, lpse_pkg::OP_LED,   24'h000000, 1'b1, 8'h00, 12},
        '{1, lpse_pkg::OP_START, 24'h5a5a5a, 1'b1, 8'h00, 64},
        '{1, lpse_pkg::OP_LED,   24'hffffff, 1'b0, 8'h00, 0},
        '{1, lpse_pkg::OP_LED,   24'h0faa55, 1'b0, 8'h00, 0},
        '{1, lpse_pkg::OP_NONE,  24'h000000, 1'b1, 8'h00, 0},
        '{1, lpse_pkg::OP_END,   24'h000000, 1'b1, 8'h00, 64},
        // lengths out of order, one pulse empty
        '{2, lpse_pkg::OP_START, 24'h000000, 1'b1, 8'h00, 1},
        '{2, lpse_pkg::OP_LED,   24'hffffff, 1'b1, 8'h00, 12},
        '{2, lpse_pkg::OP_LED,   24'h563412, 1'b0, 8'h00, 0},
        '{2, lpse_pkg::OP_END,   24'h000000, 1'b1, 8'h00, 64},
        '{3, lpse_pkg::OP_START, 24'hffffff, 1'b1, 8'h00, 0},
        '{3, lpse_pkg::OP_LED,   24'h0ff0f0, 1'b0, 8'h00, 0},
        '{3, lpse_pkg::OP_END,   24'h000000, 1'b1, 8'h00, 3},
        '{4, lpse_pkg::OP_START, 24'h000000, 1'b1, 8'h00, 64},
        '{4, lpse_pkg::OP_LED,   24'h000000, 1'b0, 8'h00, 0},
        '{4, lpse_pkg::OP_LED,   24'hffffff, 1'b0, 8'h00, 0},
        '{4, lpse_pkg::OP_END,   24'h000000, 1'b1, 8'h00, 0}
    };

    led_pulse_spi_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d bytes pending", cycle_count,
                     pending_spi_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t ns: %s mismatch, got %02h want %02h", $realtime, what, got, want);
    endtask

    // pulse pattern for one data bit at the current settings
    function automatic logic [7:0] pulse_bits(input logic [2:0] len);
        logic [7:0] run;
        logic [7:0] run_rev;
        logic [3:0] nib;
        logic [3:0] nib_rev;
        run = ((8'd1 << len) - 8'd1) << shadow.lead_low_bit;
        run_rev = {<<{run}};
        nib = run[3:0];
        nib_rev = {<<{nib}};
        if (shadow.double_packing)
            return {4'd0, shadow.msb_first ? nib_rev : nib};
        return shadow.msb_first ? run_rev : run;
    endfunction

    task automatic encode_word(input lpse_pkg::op_t op, input logic [23:0] colours);
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  v;
        logic [3:0]  first_nib;
        logic [3:0]  second_nib;
        int unsigned zeros;
        int unsigned total;
        int unsigned n;
        case (op)
            lpse_pkg::OP_START, lpse_pkg::OP_END:
            begin
                zeros = (op == lpse_pkg::OP_START) ? shadow.prefix_count
                                                   : shadow.suffix_count;
                if (zeros > lpse_pkg::RunLimit)
                    zeros = lpse_pkg::RunLimit;
                for (int k = 0; k < zeros; k++)
                    pending_spi_q.push_back(spi_word_t'{8'h00, k == zeros - 1});
            end
            lpse_pkg::OP_LED:
            begin
                p0 = pulse_bits(shadow.zero_pulse_len);
                p1 = pulse_bits(shadow.one_pulse_len);
                total = shadow.double_packing ? 12 : 24;
                n = 0;
                // green, red, blue, each from its top bit down
                for (int c = 0; c < 3; c++)
                begin
                    v = colours[8*c +: 8];
                    if (shadow.double_packing)
                    begin
                        for (int pos = 7; pos > 0; pos -= 2)
                        begin
                            first_nib = v[pos] ? p1[3:0] : p0[3:0];
                            second_nib = v[pos-1] ? p1[3:0] : p0[3:0];
                            n++;
                            pending_spi_q.push_back(spi_word_t'{
                                shadow.msb_first ? {first_nib, second_nib}
                                                 : {second_nib, first_nib},
                                n == total});
                        end
                    end
                    else
                    begin
                        for (int pos = 7; pos >= 0; pos--)
                        begin
                            n++;
                            pending_spi_q.push_back(spi_word_t'{v[pos] ? p1 : p0, n == total});
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_word(input lpse_pkg::op_t op, input logic [23:0] colours,
                             input bit typed = 1'b0, input logic [7:0] run_byte = 8'h00,
                             input int run_len = 0);
        if (typed)
        begin
            for (int k = 0; k < run_len; k++)
                pending_spi_q.push_back(spi_word_t'{run_byte, k == run_len - 1});
        end
        else
            encode_word(op, colours);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= colours;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != lpse_pkg::OP_NONE)
            words_sent++;
    endtask

    // lets the block drain before the registers change
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_spi_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input lpse_pkg::cfg_t s);
        lpse_pkg::reg_index_t idx;
        logic [6:0] value;
        for (int i = 0; i < 8; i++)
        begin
            idx = lpse_pkg::reg_index_t'(i);
            // spare upper data bits carry noise; only the field width counts
            value = 7'($urandom);
            case (idx)
                lpse_pkg::REG_ZERO_LEN:  value[2:0] = s.zero_pulse_len;
                lpse_pkg::REG_ONE_LEN:   value[2:0] = s.one_pulse_len;
                lpse_pkg::REG_LEAD_LOW:  value[0] = s.lead_low_bit;
                lpse_pkg::REG_MSB_FIRST: value[0] = s.msb_first;
                lpse_pkg::REG_DOUBLE:    value[0] = s.double_packing;
                lpse_pkg::REG_PREFIX:    value = s.prefix_count;
                lpse_pkg::REG_SUFFIX:    value = s.suffix_count;
                default:
                begin
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        shadow = s;
        settings_applied++;
    endtask

    // output side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        int unsigned hold_left;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        spi_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_spi_q.size() == 0)
                report_mismatch("byte with nothing pending", m_tdata, 8'h00);
            else
            begin
                want = pending_spi_q.pop_front();
                bytes_checked++;
                if (m_tdata !== want.spi_byte)
                    report_mismatch("spi byte", m_tdata, want.spi_byte);
                if (m_tlast !== want.last_of_run)
                    report_mismatch("last of run", {7'd0, m_tlast}, {7'd0, want.last_of_run});
            end
        end
    end

    initial
    begin
        lpse_pkg::cfg_t s;
        int             current;
        int unsigned    phase_start;
        int unsigned    frame_len;
        shadow = presets[0];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset values, no register write yet
        current = 0;
        foreach (directed[i])
        begin
            if (directed[i].setting != current)
            begin
                settle();
                current = directed[i].setting;
                apply_settings(presets[current]);
            end
            send_word(directed[i].op, directed[i].colours, directed[i].typed,
                      directed[i].run_byte, directed[i].run_len);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            s.zero_pulse_len = 3'($urandom);
            s.one_pulse_len = 3'($urandom);
            s.lead_low_bit = 1'($urandom);
            s.msb_first = 1'($urandom);
            s.double_packing = 1'($urandom);
            s.prefix_count = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(0, 6));
            s.suffix_count = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(0, 6));
            apply_settings(s);
            steady = (phase == 2);
            if (phase == 1)
                hold_request = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
            begin
                send_word(lpse_pkg::OP_START, 24'($urandom));
                frame_len = $urandom_range(1, 6);
                repeat (frame_len)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_word(lpse_pkg::OP_NONE, 24'($urandom));
                    send_word(lpse_pkg::OP_LED, 24'($urandom));
                end
                // now and then a frame is left without its end marker
                if ($urandom_range(0, 5) != 0)
                    send_word(lpse_pkg::OP_END, 24'($urandom));
            end
        end
        settle();
        steady = 1'b0;

        $display("%0d SPI bytes checked from %0d words over %0d register settings",
                 bytes_checked, words_sent, settings_applied + 1);
        $display("both packings, both bit orders, saturated runs and a long output stall");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ led_pulse_spi_encoder.f @@
hw/rtl/lpse_pkg.sv
hw/rtl/lpse_front.sv
hw/rtl/lpse_queue.sv
hw/rtl/lpse_back.sv
hw/rtl/led_pulse_spi_encoder.sv
tb/testbench.sv
